FILE: rtl/cqe_pkg.sv
// cqe_pkg: shared constants, codes and structs of the circular queue engine
// no dependencies; imported by every rtl file of the block except cqe_ram
`default_nettype none

package cqe_pkg;

	// queue geometry
	localparam int DEPTH  = 8;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// input action codes
	typedef enum logic [2:0] {
		ACT_ENQ   = 3'd0,
		ACT_DEQ   = 3'd1,
		ACT_QUERY = 3'd2,
		ACT_OVWR  = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// memory access request from the controller
	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

	// result stage carried alongside the memory read
	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [3:0] free_slots;
		logic       last;
		logic       from_ram;
	} res_t;

	// circular pointer advance
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/circular_queue_engine.sv
// circular_queue_engine: top level of the circular word queue
// depends on cqe_pkg, cqe_ctrl and cqe_ram
//
// An item is taken when start is high and busy is low. Every result shows
// on the result ports for exactly one cycle with done high, the cycle after
// the item (or the memory read) that caused it; the receiver cannot stall,
// so it must take each result in that cycle. Enqueue, dequeue, free-space
// query and overwrite never raise busy, so they may follow one another in
// every cycle. A readout of n stored words gives n results in consecutive
// cycles and holds busy high while its remaining words are read after it
// is taken: the storage memory has one read port and yields one word per
// cycle. Unused action codes give no result. Storage contents are undefined
// until written; there is no clearing pass after reset.
`default_nettype none

module circular_queue_engine import cqe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         action,
	input  wire logic signed [31:0] data_word,
	input  wire logic [2:0]         slot_index,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      read_word,
	output logic [3:0]              free_slots,
	output logic                    last_of_run
);

	ram_req_t          ram_req;
	res_t              res;
	logic [WORD_W-1:0] rd_data;

	// sequencer and pointer state
	cqe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.data_word  (WORD_W'(data_word)),
		.slot_index (slot_index),
		.busy       (busy),
		.ram_req    (ram_req),
		.res        (res)
	);

	// word storage
	cqe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rd_data)
	);

	// result transfer
	assign done        = res.valid;
	assign status      = res.status;
	assign free_slots  = res.free_slots;
	assign last_of_run = res.last;
	assign read_word   = res.from_ram ? signed'(rd_data) : 32'sd0;

endmodule

`default_nettype wire

FILE: rtl/cqe_ram.sv
// cqe_ram: generic single-write, single-read synchronous memory
// registered read data; no package dependency
`default_nettype none

module cqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/cqe_ctrl.sv
// cqe_ctrl: pointers, occupancy, readout sequencer and result stage
// depends on cqe_pkg; drives the storage memory through ram_req_t
`default_nettype none

module cqe_ctrl import cqe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        action,
	input  wire logic [WORD_W-1:0] data_word,
	input  wire logic [2:0]        slot_index,
	output logic                   busy,
	output ram_req_t               ram_req,
	output res_t                   res
);

	logic [PTR_W-1:0] front_q, front_d;
	logic [PTR_W-1:0] rear_q, rear_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [PTR_W-1:0] run_left_q, run_left_d;
	logic [PTR_W-1:0] run_ptr_q, run_ptr_d;
	res_t             res_s1, res_d;
	logic             accept;
	logic             full;
	logic             empty;

	assign busy   = (run_left_q != '0);
	assign accept = start & ~busy;
	assign full   = (occ_q == CNT_W'(DEPTH));
	assign empty  = (occ_q == '0);

	// action decode, pointer update and memory request
	always_comb begin
		front_d    = front_q;
		rear_d     = rear_q;
		occ_d      = occ_q;
		run_left_d = run_left_q;
		run_ptr_d  = run_ptr_q;
		ram_req    = '{we: 1'b0, waddr: rear_q, wdata: data_word,
			re: 1'b0, raddr: front_q};
		res_d      = '{valid: 1'b0, status: ST_OK, free_slots: 4'd0,
			last: 1'b1, from_ram: 1'b0};
		if (busy) begin
			// readout run: one word per cycle
			ram_req.re     = 1'b1;
			ram_req.raddr  = run_ptr_q;
			res_d.valid    = 1'b1;
			res_d.from_ram = 1'b1;
			res_d.last     = (run_left_q == PTR_W'(1));
			run_left_d     = run_left_q - 1'b1;
			run_ptr_d      = ptr_next(run_ptr_q);
		end else if (accept) begin
			unique case (action)
				ACT_ENQ: begin
					res_d.valid = 1'b1;
					if (full) begin
						res_d.status = ST_FULL;
					end else begin
						ram_req.we = 1'b1;
						rear_d     = ptr_next(rear_q);
						occ_d      = occ_q + 1'b1;
					end
				end
				ACT_DEQ: begin
					res_d.valid = 1'b1;
					if (empty) begin
						res_d.status = ST_EMPTY;
					end else begin
						ram_req.re     = 1'b1;
						res_d.from_ram = 1'b1;
						front_d        = ptr_next(front_q);
						occ_d          = occ_q - 1'b1;
					end
				end
				ACT_QUERY: begin
					res_d.valid = 1'b1;
					if (full) res_d.status = ST_FULL;
					else res_d.free_slots = 4'(CNT_W'(DEPTH) - occ_q);
				end
				ACT_OVWR: begin
					res_d.valid = 1'b1;
					if (int'(slot_index) < DEPTH) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = PTR_W'(slot_index);
					end else begin
						res_d.status = ST_RANGE;
					end
				end
				ACT_READ: begin
					res_d.valid = 1'b1;
					if (empty) begin
						res_d.status = ST_EMPTY;
					end else begin
						ram_req.re     = 1'b1;
						res_d.from_ram = 1'b1;
						res_d.last     = (occ_q == CNT_W'(1));
						run_left_d     = PTR_W'(occ_q - 1'b1);
						run_ptr_d      = ptr_next(front_q);
					end
				end
				default: begin
					// unused codes: no result, no state change
				end
			endcase
		end
	end

	// control state and result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			rear_q     <= '0;
			occ_q      <= '0;
			run_left_q <= '0;
			res_s1     <= '0;
		end else begin
			front_q    <= front_d;
			rear_q     <= rear_d;
			occ_q      <= occ_d;
			run_left_q <= run_left_d;
			res_s1     <= res_d;
		end
	end

	// run pointer
	always_ff @(posedge clk) begin
		run_ptr_q <= run_ptr_d;
	end

	assign res = res_s1;

endmodule

`default_nettype wire

FILE: rtl/cqe_checker.sv
// cqe_checker: port-level checks of the circular queue engine
// depends on cqe_pkg; bound to circular_queue_engine below
`default_nettype none

module cqe_checker import cqe_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [2:0]         action,
	input wire logic signed [31:0] data_word,
	input wire logic [2:0]         slot_index,
	input wire logic               done,
	input wire logic [1:0]         status,
	input wire logic signed [31:0] read_word,
	input wire logic [3:0]         free_slots,
	input wire logic               last_of_run
);

	// single-result actions answer in the next cycle with one final transfer
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_ENQ || action == ACT_DEQ ||
			action == ACT_QUERY || action == ACT_OVWR))
		|=> (done && last_of_run))
		else $error("single action did not give one final result");

	// unused codes give nothing
	a_unused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_ENQ && action != ACT_DEQ &&
			action != ACT_QUERY && action != ACT_OVWR && action != ACT_READ)
		|=> !done)
		else $error("unused action produced a result");

	// a readout run delivers a word in every busy cycle
	a_run_streams: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (done && !last_of_run && status == ST_OK))
		else $error("readout run stalled or ended early");

	// the run ends with its marked word as busy drops
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && last_of_run))
		else $error("readout run did not end with last_of_run");

	// refused items carry no word and no free count, and are marked last
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_word == 32'sd0 && free_slots == 4'd0
			&& last_of_run))
		else $error("refused item carries data");

endmodule

bind circular_queue_engine cqe_checker u_cqe_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking testbench of circular_queue_engine, one item per start/busy transfer
// depends on cqe_pkg and the rtl of the block; a queue mirror predicts every result
`timescale 1ns / 100ps

module tb;
	import cqe_pkg::*;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_ITEMS  = 400;
	localparam int          DRAIN_LIMIT   = 200;
	localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
	localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX      = 32'h7fff_ffff;

	typedef struct {
		status_t            st;
		logic signed [31:0] word;
		logic [3:0]         nfree;
		logic               last;
	} outcome_t;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] word;
		logic [2:0]  slot;
		bit          typed;
		status_t     st;
		logic [31:0] rw;
		logic [3:0]  nf;
	} script_row_t;

	typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIX} bias_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         action = ACT_ENQ;
	logic signed [31:0] data_word = '0;
	logic [2:0]         slot_index = '0;
	wire logic          busy;
	wire logic          done;
	wire logic [1:0]    status;
	wire logic signed [31:0] read_word;
	wire logic [3:0]    free_slots;
	wire logic          last_of_run;

	// mirror of the queue contents and pointers
	logic signed [31:0] mirror_mem [DEPTH];
	logic [PTR_W-1:0]   mirror_head;
	logic [PTR_W-1:0]   mirror_tail;
	int unsigned        mirror_fill;

	outcome_t    pending_results [$];
	outcome_t    want;
	script_row_t script [$];

	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned full_cnt = 0;
	int unsigned empty_cnt = 0;
	int unsigned act_cnt [8] = '{default: 0};
	bias_t       bias = BIAS_MIX;
	bit          no_idle = 1'b0;

	circular_queue_engine u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.data_word   (data_word),
		.slot_index  (slot_index),
		.done        (done),
		.status      (status),
		.read_word   (read_word),
		.free_slots  (free_slots),
		.last_of_run (last_of_run)
	);

	// clock, period 8 ns
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint exp_v);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, exp_v);
		err_cnt++;
	endtask

	function automatic void push_outcome(input status_t st, input logic [31:0] w,
			input logic [3:0] nf, input logic last);
		pending_results.push_back('{st, w, nf, last});
		if (st == ST_FULL) full_cnt++;
		if (st == ST_EMPTY) empty_cnt++;
	endfunction

	// apply one accepted item to the mirror and queue up what it must produce
	function automatic void track_queue_item(input logic [2:0] a, input logic [31:0] w,
			input logic [2:0] s);
		logic [PTR_W-1:0] p;
		int unsigned      n;
		act_cnt[a]++;
		case (a)
			ACT_ENQ: begin
				if (mirror_fill >= DEPTH) begin
					push_outcome(ST_FULL, '0, '0, 1'b1);
				end else begin
					mirror_mem[mirror_tail] = w;
					mirror_tail = (mirror_tail == PTR_W'(DEPTH - 1)) ? '0 : mirror_tail + 1'b1;
					mirror_fill++;
					push_outcome(ST_OK, '0, '0, 1'b1);
				end
			end
			ACT_DEQ: begin
				if (mirror_fill == 0) begin
					push_outcome(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					push_outcome(ST_OK, mirror_mem[mirror_head], '0, 1'b1);
					mirror_head = (mirror_head == PTR_W'(DEPTH - 1)) ? '0 : mirror_head + 1'b1;
					mirror_fill--;
				end
			end
			ACT_QUERY: begin
				if (mirror_fill >= DEPTH) push_outcome(ST_FULL, '0, '0, 1'b1);
				else push_outcome(ST_OK, '0, 4'(DEPTH - mirror_fill), 1'b1);
			end
			ACT_OVWR: begin
				if (s >= DEPTH) begin
					push_outcome(ST_RANGE, '0, '0, 1'b1);
				end else begin
					mirror_mem[s] = w;
					push_outcome(ST_OK, '0, '0, 1'b1);
				end
			end
			ACT_READ: begin
				if (mirror_fill == 0) begin
					push_outcome(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					n = mirror_fill;
					p = mirror_head;
					for (int k = 0; k < n; k++) begin
						push_outcome(ST_OK, mirror_mem[p], '0, (k + 1 == n));
						p = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
					end
				end
			end
			default: begin
				// spare codes leave everything alone
			end
		endcase
	endfunction

	// idle gap before an item: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// present one item and hold it until the transfer happens
	task automatic send(input logic [2:0] a, input logic [31:0] w, input logic [2:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= a;
		data_word  <= w;
		slot_index <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		track_queue_item(a, w, s);
	endtask

	function automatic logic [2:0] pick_action();
		int r;
		r = $urandom_range(99, 0);
		case (bias)
			BIAS_FILL: begin
				if (r < 60) return ACT_ENQ;
				if (r < 70) return ACT_DEQ;
				if (r < 78) return ACT_QUERY;
				if (r < 88) return ACT_OVWR;
				if (r < 96) return ACT_READ;
			end
			BIAS_DRAIN: begin
				if (r < 15) return ACT_ENQ;
				if (r < 65) return ACT_DEQ;
				if (r < 75) return ACT_QUERY;
				if (r < 83) return ACT_OVWR;
				if (r < 96) return ACT_READ;
			end
			default: begin
				if (r < 30) return ACT_ENQ;
				if (r < 55) return ACT_DEQ;
				if (r < 67) return ACT_QUERY;
				if (r < 80) return ACT_OVWR;
				if (r < 94) return ACT_READ;
			end
		endcase
		return 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(15, 0))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// result checker: every strobe must match the oldest pending outcome
	always @(posedge clk) begin
		if (arst_n && done) begin
			result_cnt++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending, status", status, -1);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) flag_mismatch("status", status, want.st);
				if (read_word !== want.word) flag_mismatch("read_word", read_word, want.word);
				if (free_slots !== want.nfree) flag_mismatch("free_slots", free_slots, want.nfree);
				if (last_of_run !== want.last) flag_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[%0t] run limit reached with %0d results pending", $time,
				pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int seg_left;
		int drain;
		script_row_t r;

		mirror_head = '0;
		mirror_tail = '0;
		mirror_fill = 0;
		foreach (mirror_mem[i]) mirror_mem[i] = '0;

		// directed rows: empty after reset, extremes, full, in-place overwrite, wrap
		script.push_back('{ACT_DEQ,   '0,           3'd0, 1'b1, ST_EMPTY, '0, 4'd0});
		script.push_back('{ACT_READ,  '0,           3'd0, 1'b1, ST_EMPTY, '0, 4'd0});
		script.push_back('{ACT_QUERY, '0,           3'd0, 1'b1, ST_OK,    '0, 4'd8});
		script.push_back('{3'(ACT_UNUSED_LO), '1,   3'd7, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   WORD_MIN,     3'd7, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   WORD_MAX,     3'd0, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_READ,  '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   '0,           3'd0, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   '1,           3'd0, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'h5555_5555, 3'd5, 1'b1, ST_OK,   '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'haaaa_aaaa, 3'd2, 1'b1, ST_OK,   '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'd1,        3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'h1234_5678, 3'd0, 1'b0, ST_OK,   '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'd77,       3'd0, 1'b1, ST_FULL,  '0, 4'd0});
		script.push_back('{ACT_QUERY, '0,           3'd0, 1'b1, ST_FULL,  '0, 4'd0});
		script.push_back('{ACT_OVWR,  32'd42,       3'd0, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_OVWR,  WORD_MIN,     3'd7, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_READ,  '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_DEQ,   '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_DEQ,   '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_ENQ,   32'd99,       3'd0, 1'b1, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_QUERY, '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_UNUSED_HI, '0,       3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{ACT_READ,  '0,           3'd0, 1'b0, ST_OK,    '0, 4'd0});
		script.push_back('{3'd6,      32'h0f0f_0f0f, 3'd3, 1'b0, ST_OK,   '0, 4'd0});

		// hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: typed rows replace the mirror's single outcome
		foreach (script[i]) begin
			r = script[i];
			send(r.act, r.word, r.slot);
			if (r.typed) begin
				void'(pending_results.pop_back());
				pending_results.push_back('{r.st, r.rw, r.nf, 1'b1});
			end
		end

		// random part in segments that lean toward filling, draining or neither
		seg_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 10);
				bias     = bias_t'($urandom_range(2, 0));
				no_idle  = ($urandom_range(3, 0) == 0);
			end
			seg_left--;
			send(pick_action(), pick_word(), 3'($urandom_range(7, 0)));
		end
		start <= 1'b0;

		// drain what is still on its way
		drain = 0;
		while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never seen, count", 0, pending_results.size());

		$display("covered %0d enqueue, %0d dequeue, %0d query, %0d overwrite, %0d readout, %0d spare-code items",
			act_cnt[ACT_ENQ], act_cnt[ACT_DEQ], act_cnt[ACT_QUERY], act_cnt[ACT_OVWR],
			act_cnt[ACT_READ], act_cnt[5] + act_cnt[6] + act_cnt[7]);
		$display("%0d results checked, %0d full refusals, %0d empty answers, %0d mismatches",
			result_cnt, full_cnt, empty_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/cqe_pkg.sv
rtl/cqe_ram.sv
rtl/cqe_ctrl.sv
rtl/circular_queue_engine.sv
rtl/cqe_checker.sv
sim/tb.sv
